// ----- design/rlpl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlpl_pkg : shared types and constants of the route lookup engine
// Route record layout, sequencer states, the scan control bundle and the
// prefix length count used when a route is installed.
// ----------------------------------------------------------------------------
package rlpl_pkg;

    // Field widths fixed by the item format
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 2;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned LEN_W   = 6;

    // Number of outgoing interfaces; installs naming a port at or above this are dropped
    localparam int unsigned NUM_PORTS = 4;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // One stored route, prefix length worked out when it is written
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic [LEN_W-1:0]  len;
    } t_route;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Control from the sequencer to the match unit
    typedef struct packed {
        logic clear;   // start of a lookup: forget the previous best
        logic eval;    // table read data is valid this cycle
    } t_scan_ctl;

    // Count of one bits in a mask, as a short tree of field sums
    function automatic logic [LEN_W-1:0] ones_in(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] x;
        x = v - ((v >> 1) & 32'h5555_5555);
        x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
        x = (x + (x >> 4)) & 32'h0F0F_0F0F;
        x = x + (x >> 8);
        x = x + (x >> 16);
        // low byte now holds the full count, at most 32
        return LEN_W'(x);
    endfunction

endpackage
`default_nettype wire

// ----- design/rlpl_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlpl_table : route table storage
// Route records sit in a memory with one write port and one registered read port; the
// valid bits are flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module rlpl_table #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned IDX_W       = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr_en,
    input  wire [IDX_W-1:0]      i_wr_addr,
    input  wire                  i_wr_valid,
    input  wire rlpl_pkg::t_route i_wr_data,
    input  wire                  i_rd_en,
    input  wire [IDX_W-1:0]      i_rd_addr,
    output logic                 o_rd_valid,
    output rlpl_pkg::t_route     o_rd_data
);

    rlpl_pkg::t_route r_mem [TABLE_DEPTH];
    logic             r_valid [TABLE_DEPTH];

    // Record memory: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            o_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= i_wr_valid;
            end
            if (i_rd_en) begin
                o_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/rlpl_match.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlpl_match : shared compare unit
// Checks one route a cycle against the lookup address and keeps the best
// match so far: longest prefix, earliest slot on a tie.
// ----------------------------------------------------------------------------
module rlpl_match #(
    parameter int unsigned IDX_W = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire rlpl_pkg::t_scan_ctl     i_ctl,
    input  wire [rlpl_pkg::ADDR_W-1:0]   i_addr,
    input  wire                          i_rd_valid,
    input  wire rlpl_pkg::t_route        i_rd_data,
    input  wire [IDX_W-1:0]              i_rd_idx,
    output logic                         o_found,
    output logic [IDX_W-1:0]             o_best_idx,
    output logic [rlpl_pkg::LEN_W-1:0]   o_best_len,
    output logic [rlpl_pkg::ADDR_W-1:0]  o_best_gw,
    output logic [rlpl_pkg::PORT_W-1:0]  o_best_port
);

    logic w_match;
    logic w_take;

    // Masked compare and length compare
    assign w_match = i_rd_valid && ((i_addr & i_rd_data.mask) == i_rd_data.dest);
    assign w_take  = w_match && (!o_found || (i_rd_data.len > o_best_len));

    // Found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_found <= 1'b0;
        end else if (i_ctl.clear) begin
            o_found <= 1'b0;
        end else if (i_ctl.eval && w_take) begin
            o_found <= 1'b1;
        end
    end

    // Best route so far
    always_ff @(posedge i_clk) begin
        if (i_ctl.eval && w_take && !i_ctl.clear) begin
            o_best_idx  <= i_rd_idx;
            o_best_len  <= i_rd_data.len;
            o_best_gw   <= i_rd_data.gateway;
            o_best_port <= i_rd_data.port;
        end
    end

endmodule
`default_nettype wire

// ----- design/route_longest_prefix_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// route_longest_prefix_lookup : IPv4 longest prefix match route table
// A write item loads or clears one slot, if the slot and port are in range,
// and goes straight to the done state. A lookup item reads the table one slot
// a cycle through the shared compare unit, the table having a single read
// port, then passes through the drain and done states. Input ready is low
// while an item is in progress; a finished result waits in the done state
// until the output register is empty or being read, and the next item is
// taken once the result has been loaded there. Every item gives exactly one
// result; writes give an all-zero result.
// ----------------------------------------------------------------------------
module route_longest_prefix_lookup #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire                                i_operation,
    input  wire [rlpl_pkg::SLOT_W-1:0]         i_entry_index,
    input  wire                                i_entry_valid,
    input  wire [rlpl_pkg::ADDR_W-1:0]         i_entry_dest,
    input  wire [rlpl_pkg::ADDR_W-1:0]         i_entry_mask,
    input  wire [rlpl_pkg::ADDR_W-1:0]         i_entry_gateway,
    input  wire [rlpl_pkg::PORT_W-1:0]         i_entry_port,
    input  wire [rlpl_pkg::ADDR_W-1:0]         i_lookup_addr,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic                               o_hit,
    output logic [rlpl_pkg::SLOT_W-1:0]        o_matched_index,
    output logic [rlpl_pkg::ADDR_W-1:0]        o_next_hop,
    output logic [rlpl_pkg::PORT_W-1:0]        o_out_port,
    output logic [rlpl_pkg::LEN_W-1:0]         o_prefix_length
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    rlpl_pkg::t_state    r_state, n_state;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic                r_lookup, n_lookup;
    logic [rlpl_pkg::ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_rd_pend;

    logic                w_accept;
    logic                w_wr_en;
    logic                w_rd_en;
    logic                w_load;
    rlpl_pkg::t_route    w_wr_data;
    rlpl_pkg::t_scan_ctl w_ctl;

    logic                w_rd_valid;
    rlpl_pkg::t_route    w_rd_data;
    logic                w_found;
    logic [IDX_W-1:0]    w_best_idx;
    logic [rlpl_pkg::LEN_W-1:0]  w_best_len;
    logic [rlpl_pkg::ADDR_W-1:0] w_best_gw;
    logic [rlpl_pkg::PORT_W-1:0] w_best_port;

    assign o_ready  = (r_state == rlpl_pkg::ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // Write filtering: slot in range, and a valid port when installing
    assign w_wr_en = w_accept && (i_operation == rlpl_pkg::OP_WRITE)
                     && (32'(i_entry_index) < TABLE_DEPTH)
                     && (!i_entry_valid
                         || (32'(i_entry_port) < rlpl_pkg::NUM_PORTS));

    always_comb begin
        w_wr_data.dest    = i_entry_dest;
        w_wr_data.mask    = i_entry_mask;
        w_wr_data.gateway = i_entry_gateway;
        w_wr_data.port    = i_entry_port;
        w_wr_data.len     = rlpl_pkg::ones_in(i_entry_mask);
    end

    // Sequencer: next state and controls
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_lookup  = r_lookup;
        w_rd_en   = 1'b0;
        w_load    = 1'b0;
        w_ctl.clear = 1'b0;
        w_ctl.eval  = r_rd_pend;
        case (r_state)
            rlpl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_lookup = (i_operation == rlpl_pkg::OP_LOOKUP);
                    n_cnt    = '0;
                    if (i_operation == rlpl_pkg::OP_LOOKUP) begin
                        w_ctl.clear = 1'b1;
                        n_state     = rlpl_pkg::ST_SCAN;
                    end else begin
                        n_state = rlpl_pkg::ST_DONE;
                    end
                end
            end
            rlpl_pkg::ST_SCAN: begin
                w_rd_en = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = rlpl_pkg::ST_DRAIN;
                end
            end
            rlpl_pkg::ST_DRAIN: begin
                n_state = rlpl_pkg::ST_DONE;
            end
            rlpl_pkg::ST_DONE: begin
                if (!o_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = rlpl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rlpl_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rlpl_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_lookup  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_lookup  <= n_lookup;
            r_rd_pend <= w_rd_en;
        end
    end

    // Lookup address and slot of the read in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= i_lookup_addr;
        end
        if (w_rd_en) begin
            r_rd_idx <= r_cnt;
        end
    end

    rlpl_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (IDX_W'(i_entry_index)),
        .i_wr_valid (i_entry_valid),
        .i_wr_data  (w_wr_data),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (r_cnt),
        .o_rd_valid (w_rd_valid),
        .o_rd_data  (w_rd_data)
    );

    rlpl_match #(
        .IDX_W (IDX_W)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_addr      (r_addr),
        .i_rd_valid  (w_rd_valid),
        .i_rd_data   (w_rd_data),
        .i_rd_idx    (r_rd_idx),
        .o_found     (w_found),
        .o_best_idx  (w_best_idx),
        .o_best_len  (w_best_len),
        .o_best_gw   (w_best_gw),
        .o_best_port (w_best_port)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    // Output item: all zero for writes and misses
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_lookup && w_found) begin
                o_hit           <= 1'b1;
                o_matched_index <= rlpl_pkg::SLOT_W'(w_best_idx);
                o_next_hop      <= (w_best_gw != '0) ? w_best_gw : r_addr;
                o_out_port      <= w_best_port;
                o_prefix_length <= w_best_len;
            end else begin
                o_hit           <= 1'b0;
                o_matched_index <= '0;
                o_next_hop      <= '0;
                o_out_port      <= '0;
                o_prefix_length <= '0;
            end
        end
    end

endmodule
`default_nettype wire
